// ===== rtl/pfd_pkg.sv =====
// Shared types, constants and codes for the filtered-derivative PID block.
// Used by every module under rtl; depends on nothing else.
package pfd_pkg;

  localparam int SMP_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DELTA_W = 18;
  localparam int SLOPE_W = 18;
  localparam int INT_W   = 24;
  localparam int ISUM_W  = INT_W + 1;
  localparam int GAIN_W  = 16;
  localparam int DRV_W   = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 24;
  localparam int OPA_W   = 24;
  localparam int OPB_W   = 16;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int ACC_W   = 42;
  localparam int FRAC_W  = 8;
  localparam int SHR_W   = ACC_W - FRAC_W;

  localparam logic signed [OPB_W-1:0]   ALPHA_NEW = 16'sd51;
  localparam logic signed [OPB_W-1:0]   ALPHA_OLD = 16'sd205;
  localparam logic signed [ACC_W-1:0]   ROUND_HALF = 42'sd128;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 18'sd131071;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = -18'sd131072;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_P   = 16'sd6400;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I   = 16'sd0;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D   = 16'sd768;
  localparam logic signed [INT_W-1:0]  RST_INT_UP   = 24'sd0;
  localparam logic signed [INT_W-1:0]  RST_INT_LO   = 24'sd0;
  localparam logic signed [DRV_W-1:0]  RST_DRV_UP   = 16'sd500;
  localparam logic signed [DRV_W-1:0]  RST_DRV_LO   = -16'sd500;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_INT_UP  = 3'd3,
    REG_INT_LO  = 3'd4,
    REG_DRV_UP  = 3'd5,
    REG_DRV_LO  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD     = 2'd1,
    ACC_LOAD_RND = 2'd2,
    ACC_ADD      = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [INT_W-1:0]  int_up;
    logic signed [INT_W-1:0]  int_lo;
    logic signed [DRV_W-1:0]  drv_up;
    logic signed [DRV_W-1:0]  drv_lo;
  } cfg_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_CALC = 10'b00_0000_0010,
    S_MA   = 10'b00_0000_0100,
    S_MB   = 10'b00_0000_1000,
    S_FA   = 10'b00_0001_0000,
    S_FS   = 10'b00_0010_0000,
    S_P    = 10'b00_0100_0000,
    S_I    = 10'b00_1000_0000,
    S_D    = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/pfd_cfg.sv =====
// Configuration register file for the filtered-derivative PID block.
// Depends on pfd_pkg for the register codes, widths and reset values.
module pfd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pfd_pkg::DATA_W-1:0]  cfg_data,
  output pfd_pkg::cfg_t               cfg
);

  pfd_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p <= pfd_pkg::RST_GAIN_P;
      regs.gain_i <= pfd_pkg::RST_GAIN_I;
      regs.gain_d <= pfd_pkg::RST_GAIN_D;
      regs.int_up <= pfd_pkg::RST_INT_UP;
      regs.int_lo <= pfd_pkg::RST_INT_LO;
      regs.drv_up <= pfd_pkg::RST_DRV_UP;
      regs.drv_lo <= pfd_pkg::RST_DRV_LO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfd_pkg::reg_idx_t'(cfg_index))
        pfd_pkg::REG_GAIN_P: regs.gain_p <= cfg_data[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_GAIN_I: regs.gain_i <= cfg_data[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_GAIN_D: regs.gain_d <= cfg_data[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_INT_UP: regs.int_up <= cfg_data[pfd_pkg::INT_W-1:0];
        pfd_pkg::REG_INT_LO: regs.int_lo <= cfg_data[pfd_pkg::INT_W-1:0];
        pfd_pkg::REG_DRV_UP: regs.drv_up <= cfg_data[pfd_pkg::DRV_W-1:0];
        pfd_pkg::REG_DRV_LO: regs.drv_lo <= cfg_data[pfd_pkg::DRV_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/pfd_mac.sv =====
// Shared signed multiply-accumulate unit: registered product, then accumulator.
// Depends on pfd_pkg for operand widths and the accumulator operation codes.
module pfd_mac (
  input  logic                              clk,
  input  pfd_pkg::mac_ctrl_t                ctrl,
  input  logic signed [pfd_pkg::OPA_W-1:0]  op_a,
  input  logic signed [pfd_pkg::OPB_W-1:0]  op_b,
  output logic signed [pfd_pkg::ACC_W-1:0]  acc
);

  logic signed [pfd_pkg::PROD_W-1:0] prod;
  logic signed [pfd_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = pfd_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
    unique case (ctrl.acc_op)
      pfd_pkg::ACC_HOLD:     acc <= acc;
      pfd_pkg::ACC_LOAD:     acc <= prod_ext;
      pfd_pkg::ACC_LOAD_RND: acc <= prod_ext + pfd_pkg::ROUND_HALF;
      pfd_pkg::ACC_ADD:      acc <= acc + prod_ext;
      default:               acc <= acc;
    endcase
  end

endmodule

// ===== rtl/pfd_seq.sv =====
// Sequencer and state registers of the filtered-derivative PID block.
// Depends on pfd_pkg and instantiates the shared multiply-accumulate unit pfd_mac.
module pfd_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  pfd_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pfd_pkg::SMP_W-1:0]  measured,
  input  logic signed [pfd_pkg::SMP_W-1:0]  setpoint,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pfd_pkg::DRV_W-1:0]  drive,
  output pfd_pkg::state_t                   state
);

  pfd_pkg::state_t state_next;
  pfd_pkg::mac_ctrl_t ctrl;

  logic signed [pfd_pkg::ERR_W-1:0]   err;
  logic signed [pfd_pkg::ERR_W-1:0]   prior_error;
  logic signed [pfd_pkg::DELTA_W-1:0] delta;
  logic signed [pfd_pkg::INT_W-1:0]   integral_sum;
  logic signed [pfd_pkg::ISUM_W-1:0]  isum_work;
  logic signed [pfd_pkg::SLOPE_W-1:0] filtered_slope;
  logic                               warmed_up;
  logic                               win;

  logic signed [pfd_pkg::OPA_W-1:0]   op_a;
  logic signed [pfd_pkg::OPB_W-1:0]   op_b;
  logic signed [pfd_pkg::ACC_W-1:0]   acc;
  logic signed [pfd_pkg::SHR_W-1:0]   acc_shr;

  logic signed [pfd_pkg::ERR_W-1:0]   err_in;
  logic        [pfd_pkg::ERR_W-1:0]   err_mag;
  logic signed [pfd_pkg::INT_W+1:0]   win_lim;
  logic signed [pfd_pkg::SLOPE_W-1:0] slope_sat;
  logic signed [pfd_pkg::DRV_W-1:0]   drive_sat;
  logic signed [pfd_pkg::SHR_W-1:0]   drv_hi_clip;
  logic                               out_load;

  assign in_stall = (state != pfd_pkg::S_IDLE);
  assign acc_shr  = acc[pfd_pkg::ACC_W-1:pfd_pkg::FRAC_W];
  assign err_in   = pfd_pkg::ERR_W'(setpoint) - pfd_pkg::ERR_W'(measured);
  assign err_mag  = err[pfd_pkg::ERR_W-1] ? -err : err;
  assign win_lim  = {cfg.int_up[pfd_pkg::INT_W-1], cfg.int_up, 1'b0};
  assign out_load = !out_valid || !out_stall;

  pfd_mac u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  always_comb begin
    ctrl.mul_en = 1'b0;
    ctrl.acc_op = pfd_pkg::ACC_HOLD;
    op_a        = pfd_pkg::OPA_W'(err);
    op_b        = cfg.gain_p;
    state_next  = state;
    unique case (state)
      pfd_pkg::S_IDLE: begin
        if (in_valid) state_next = pfd_pkg::S_CALC;
      end
      pfd_pkg::S_CALC: state_next = pfd_pkg::S_MA;
      pfd_pkg::S_MA: begin
        ctrl.mul_en = 1'b1;
        op_a        = pfd_pkg::OPA_W'(delta);
        op_b        = pfd_pkg::ALPHA_NEW;
        state_next  = pfd_pkg::S_MB;
      end
      pfd_pkg::S_MB: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = pfd_pkg::ACC_LOAD_RND;
        op_a        = pfd_pkg::OPA_W'(filtered_slope);
        op_b        = pfd_pkg::ALPHA_OLD;
        state_next  = pfd_pkg::S_FA;
      end
      pfd_pkg::S_FA: begin
        ctrl.acc_op = pfd_pkg::ACC_ADD;
        state_next  = pfd_pkg::S_FS;
      end
      pfd_pkg::S_FS: begin
        ctrl.mul_en = 1'b1;
        op_a        = pfd_pkg::OPA_W'(err);
        op_b        = cfg.gain_p;
        state_next  = pfd_pkg::S_P;
      end
      pfd_pkg::S_P: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = pfd_pkg::ACC_LOAD;
        op_a        = integral_sum;
        op_b        = cfg.gain_i;
        state_next  = pfd_pkg::S_I;
      end
      pfd_pkg::S_I: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = pfd_pkg::ACC_ADD;
        op_a        = pfd_pkg::OPA_W'(filtered_slope);
        op_b        = cfg.gain_d;
        state_next  = pfd_pkg::S_D;
      end
      pfd_pkg::S_D: begin
        ctrl.acc_op = warmed_up ? pfd_pkg::ACC_ADD : pfd_pkg::ACC_HOLD;
        state_next  = pfd_pkg::S_OUT;
      end
      pfd_pkg::S_OUT: begin
        if (out_load) state_next = pfd_pkg::S_IDLE;
      end
      default: state_next = pfd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (acc_shr > pfd_pkg::SHR_W'(pfd_pkg::SLOPE_MAX)) begin
      slope_sat = pfd_pkg::SLOPE_MAX;
    end else if (acc_shr < pfd_pkg::SHR_W'(pfd_pkg::SLOPE_MIN)) begin
      slope_sat = pfd_pkg::SLOPE_MIN;
    end else begin
      slope_sat = acc_shr[pfd_pkg::SLOPE_W-1:0];
    end
    if (acc_shr > pfd_pkg::SHR_W'(cfg.drv_up)) begin
      drv_hi_clip = pfd_pkg::SHR_W'(cfg.drv_up);
    end else begin
      drv_hi_clip = acc_shr;
    end
    if (drv_hi_clip < pfd_pkg::SHR_W'(cfg.drv_lo)) begin
      drive_sat = cfg.drv_lo;
    end else begin
      drive_sat = drv_hi_clip[pfd_pkg::DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pfd_pkg::S_IDLE;
      out_valid      <= 1'b0;
      warmed_up      <= 1'b0;
      prior_error    <= '0;
      integral_sum   <= '0;
      filtered_slope <= '0;
    end else begin
      state <= state_next;
      if ((state == pfd_pkg::S_OUT) && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pfd_pkg::S_IDLE: begin
          if (in_valid) err <= err_in;
        end
        pfd_pkg::S_CALC: begin
          delta <= pfd_pkg::DELTA_W'(err) - pfd_pkg::DELTA_W'(prior_error);
          win   <= $signed({1'b0, err_mag}) < win_lim;
        end
        pfd_pkg::S_MA: begin
          isum_work <= win ? pfd_pkg::ISUM_W'(integral_sum) + pfd_pkg::ISUM_W'(err)
                           : pfd_pkg::ISUM_W'(integral_sum);
        end
        pfd_pkg::S_MB: begin
          if (isum_work > pfd_pkg::ISUM_W'(cfg.int_up)) begin
            isum_work <= pfd_pkg::ISUM_W'(cfg.int_up);
          end
        end
        pfd_pkg::S_FA: begin
          if (isum_work < pfd_pkg::ISUM_W'(cfg.int_lo)) begin
            integral_sum <= cfg.int_lo;
          end else begin
            integral_sum <= isum_work[pfd_pkg::INT_W-1:0];
          end
        end
        pfd_pkg::S_FS: begin
          filtered_slope <= slope_sat;
          prior_error    <= err;
        end
        pfd_pkg::S_D: begin
          warmed_up <= 1'b1;
        end
        pfd_pkg::S_OUT: begin
          if (out_load) begin
            drive <= drive_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/pid_filtered_derivative.sv =====
// Top level of the PID controller with windowed integration and filtered derivative.
// Depends on pfd_pkg and instantiates pfd_cfg and pfd_seq.
//
// The block takes one beat of measured and setpoint when in_stall is low, works it
// through the sequencer steps CALC, MA, MB, FA, FS, P, I, D and OUT, and presents one
// drive beat in its output register; only then does it take the next input beat. The
// single shared multiply-accumulate unit forms the five products of an item in turn
// under a small sequencer. If the previous drive beat is still held by out_stall, the
// sequencer waits with the finished result until the output register is free. The user
// is to write configuration registers only while the block is idle; the block does not
// enforce this. Writes to an unknown index are ignored.
module pid_filtered_derivative (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfd_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pfd_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pfd_pkg::SMP_W-1:0]  measured,
  input  logic signed [pfd_pkg::SMP_W-1:0]  setpoint,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pfd_pkg::DRV_W-1:0]  drive
);

  pfd_pkg::cfg_t   cfg;
  pfd_pkg::state_t state;

  pfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .measured  (measured),
    .setpoint  (setpoint),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .state     (state)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is still being worked on");

  a_result_from_final_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == pfd_pkg::S_OUT))
    else $error("drive beat raised outside the final sequencer step");

  a_drive_in_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cfg.drv_lo <= cfg.drv_up) |-> (drive >= cfg.drv_lo) && (drive <= cfg.drv_up))
    else $error("drive beat outside the configured output limits");

endmodule

// ===== tb/sv/pfd_drive_checker.sv =====
`timescale 1ns / 100ps
// Watches the configuration, sample and drive channels of pid_filtered_derivative,
// predicts every drive beat and compares it. Depends on pfd_pkg for widths and indexes.
module pfd_drive_checker
  import pfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [DATA_W-1:0]          cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SMP_W-1:0]    measured,
  input  logic signed [SMP_W-1:0]    setpoint,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [DRV_W-1:0]    drive,
  output int                         mismatches,
  output int                         outstanding
);

  localparam longint WEIGHT_FRESH = 51;
  localparam longint WEIGHT_HELD  = 205;
  localparam longint HALF_LSB     = 128;
  localparam longint SLOPE_TOP    = 131071;
  localparam longint SLOPE_BOTTOM = -131072;

  cfg_t                       cfg;
  logic signed [ERR_W-1:0]    last_error;
  logic signed [INT_W-1:0]    integ;
  logic signed [SLOPE_W-1:0]  slope;
  logic                       warm;
  logic signed [DRV_W-1:0]    drive_queue[$];
  int                         beat_no;
  int                         fail_total;

  function automatic longint clip(input longint v, input longint hi, input longint lo);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic logic signed [DRV_W-1:0] next_drive(input logic signed [SMP_W-1:0] m,
                                                          input logic signed [SMP_W-1:0] s);
    longint err;
    longint acc;
    longint shaped;
    longint sum;
    err = longint'(s) - longint'(m);
    acc = longint'(integ);
    if ((err < 0 ? -err : err) < 2 * longint'(cfg.int_up)) acc += err;
    integ = INT_W'(clip(acc, cfg.int_up, cfg.int_lo));
    shaped = (WEIGHT_FRESH * (err - longint'(last_error)) + WEIGHT_HELD * longint'(slope)
              + HALF_LSB) >>> 8;
    slope = SLOPE_W'(clip(shaped, SLOPE_TOP, SLOPE_BOTTOM));
    last_error = ERR_W'(err);
    sum = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * longint'(integ);
    if (warm) sum += longint'(cfg.gain_d) * longint'(slope);
    warm = 1'b1;
    return DRV_W'(clip(sum >>> 8, cfg.drv_up, cfg.drv_lo));
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] drive beat %0d: %s", $realtime, beat_no, what);
    fail_total++;
  endtask

  always @(posedge clk) begin
    logic signed [DRV_W-1:0] wanted;
    if (rst) begin
      cfg = '{gain_p: 16'sd6400, gain_i: 16'sd0, gain_d: 16'sd768, int_up: 24'sd0,
              int_lo: 24'sd0, drv_up: 16'sd500, drv_lo: -16'sd500};
      last_error = '0;
      integ = '0;
      slope = '0;
      warm = 1'b0;
      drive_queue.delete();
      beat_no = 0;
      fail_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, drive %0d", drive));
        end else begin
          wanted = drive_queue.pop_front();
          if (drive !== wanted)
            report_mismatch($sformatf("drive %0d, expected %0d", drive, wanted));
        end
        beat_no++;
      end
      if (in_valid && !in_stall) drive_queue.push_back(next_drive(measured, setpoint));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P: cfg.gain_p = cfg_data[GAIN_W-1:0];
          REG_GAIN_I: cfg.gain_i = cfg_data[GAIN_W-1:0];
          REG_GAIN_D: cfg.gain_d = cfg_data[GAIN_W-1:0];
          REG_INT_UP: cfg.int_up = cfg_data[INT_W-1:0];
          REG_INT_LO: cfg.int_lo = cfg_data[INT_W-1:0];
          REG_DRV_UP: cfg.drv_up = cfg_data[DRV_W-1:0];
          REG_DRV_LO: cfg.drv_lo = cfg_data[DRV_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= drive_queue.size();
    mismatches <= fail_total;
  end

endmodule

// ===== tb/sv/tb_pid_filtered_derivative.sv =====
`timescale 1ns / 100ps
// Top of the pid_filtered_derivative testbench: clock, reset, configuration, sample
// stimulus and output back-pressure. Depends on pfd_pkg and pfd_drive_checker.
module tb_pid_filtered_derivative;
  import pfd_pkg::*;

  localparam real             CLK_PERIOD  = 12.0;
  localparam logic [IDX_W-1:0] REG_SPARE  = 3'd7;
  localparam int              HOLD_CYCLES = 300;
  localparam int              SETTLE      = 12;
  localparam int              PHASES      = 8;
  localparam int              PHASE_ITEMS = 110;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index;
  logic [DATA_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SMP_W-1:0]   measured;
  logic signed [SMP_W-1:0]   setpoint;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [DRV_W-1:0]   drive;
  int                        mismatches;
  int                        outstanding;
  logic                      tx_gaps;
  logic                      rx_gaps;
  logic                      hold_request;

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  pid_filtered_derivative dut (.*);

  pfd_drive_checker checker_i (.*);

  function automatic cfg_t make_cfg(input int p, input int i, input int d, input int iu,
                                    input int il, input int du, input int dl);
    cfg_t c;
    c.gain_p = GAIN_W'(p);
    c.gain_i = GAIN_W'(i);
    c.gain_d = GAIN_W'(d);
    c.int_up = INT_W'(iu);
    c.int_lo = INT_W'(il);
    c.drv_up = DRV_W'(du);
    c.drv_lo = DRV_W'(dl);
    return c;
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(65535)) - 32768;
      default: return int'($urandom_range(2047)) - 1024;
    endcase
  endfunction

  function automatic cfg_t random_cfg(input int phase);
    int iu;
    int il;
    int du;
    int dl;
    if (phase == 0) return make_cfg(32767, 32767, 32767, 8388607, -8388608, 32767, -32768);
    if (phase == 1) return make_cfg(-32768, -32768, -32768, -8388608, 8388607, -32768, 32767);
    iu = ($urandom_range(3) == 0) ? int'($urandom_range(16777215)) - 8388608
                                  : int'($urandom_range(50000));
    il = ($urandom_range(3) == 0) ? int'($urandom_range(16777215)) - 8388608
                                  : -int'($urandom_range(50000));
    du = ($urandom_range(2) == 0) ? int'($urandom_range(65535)) - 32768 : 32767;
    dl = ($urandom_range(2) == 0) ? int'($urandom_range(65535)) - 32768 : -32768;
    return make_cfg(rand_gain(), rand_gain(), rand_gain(), iu, il, du, dl);
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    drain();
    write_reg(REG_SPARE, DATA_W'($urandom));
    write_reg(REG_GAIN_P, DATA_W'(c.gain_p));
    write_reg(REG_GAIN_I, DATA_W'(c.gain_i));
    write_reg(REG_GAIN_D, DATA_W'(c.gain_d));
    write_reg(REG_INT_UP, DATA_W'(c.int_up));
    write_reg(REG_INT_LO, DATA_W'(c.int_lo));
    write_reg(REG_DRV_UP, DATA_W'(c.drv_up));
    write_reg(REG_DRV_LO, DATA_W'(c.drv_lo));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input int m, input int s);
    if (tx_gaps && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured <= SMP_W'(m);
    setpoint <= SMP_W'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_sample();
    int s;
    if ($urandom_range(9) < 3) begin
      send_sample(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
    end else begin
      s = int'($urandom_range(2000)) - 1000;
      send_sample(s + int'($urandom_range(600)) - 300, s);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= rx_gaps && ($urandom_range(99) < 25);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    measured = '0;
    setpoint = '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The first beat after reset carries no derivative term.
    send_sample(100, 120);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(5, -5);

    load_config(make_cfg(256, 128, 512, 1000, -1000, 32767, -32768));
    send_sample(0, 10);
    send_sample(0, 1999);
    send_sample(0, 2000);
    send_sample(2000, 0);
    send_sample(1999, 0);
    send_sample(0, 300);
    send_sample(0, 300);

    // An empty window, then floors lying above their ceilings.
    load_config(make_cfg(300, 32767, 200, -5, -100, 32767, -32768));
    send_sample(3, 0);
    load_config(make_cfg(300, 256, 200, 50, 200, -100, 100));
    send_sample(0, 7);
    send_sample(40, 0);

    load_config(make_cfg(-32768, 32767, 32767, 8388607, -8388608, 32767, -32768));
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(0, 1);
    send_sample(1, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      load_config(random_cfg(phase));
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 2);
      if (phase == 4) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) drain();
        send_random_sample();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** pid_filtered_derivative: PASSED **");
    end else begin
      $display("** pid_filtered_derivative: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** pid_filtered_derivative: FAILED **");
    $finish;
  end

endmodule
